[rtl/core/spei_pkg.sv]
// package for the semi-parabolic escape iteration unit
// types, constants and fixed point helpers; no dependencies
`default_nettype none

package spei_pkg;

    localparam int ITER_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 28;
    localparam int Q_W            = 48;
    localparam int RAW_W          = 64;
    localparam int ACC_W          = 96;
    localparam int HALF_W         = 24;
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int STEP_W         = 16;
    localparam int ESC_W          = 16;
    localparam int NUM_PROD       = 22;
    localparam int QUO_W          = 47;

    typedef logic signed [Q_W-1:0]   t_q;
    typedef logic signed [RAW_W-1:0] t_raw;
    typedef logic [4:0]              t_pidx;

    localparam t_q Q_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_q Q_MIN = 48'sh8000_0000_0000;
    localparam t_q Q_ONE = 48'sh0001_0000_0000;
    localparam t_q Q_ZERO = 48'sh0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_REAL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_IMAG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_REAL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_IMAG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT = 3'd5;

    localparam logic [31:0] RST_EPS_REAL     = 32'd13421773;
    localparam logic [31:0] RST_EPS_IMAG     = 32'd0;
    localparam logic [31:0] RST_COEF_REAL    = 32'd80530637;
    localparam logic [31:0] RST_COEF_IMAG    = 32'd0;
    localparam int          RST_MAX_ITER     = 200;
    localparam logic [15:0] RST_ESCAPE_LIMIT = 16'd10000;

    // product slots of the shared multiplier
    localparam t_pidx P_ER_ER   = 5'd0;
    localparam t_pidx P_EI_EI   = 5'd1;
    localparam t_pidx P_ER_EI   = 5'd2;
    localparam t_pidx P_DR_DR   = 5'd3;
    localparam t_pidx P_DI_DI   = 5'd4;
    localparam t_pidx P_E2R_DR  = 5'd5;
    localparam t_pidx P_E2I_DI  = 5'd6;
    localparam t_pidx P_E2I_DR  = 5'd7;
    localparam t_pidx P_E2R_DI  = 5'd8;
    localparam t_pidx P_XR_XR   = 5'd9;
    localparam t_pidx P_XI_XI   = 5'd10;
    localparam t_pidx P_YR_YR   = 5'd11;
    localparam t_pidx P_YI_YI   = 5'd12;
    localparam t_pidx P_AR_XR   = 5'd13;
    localparam t_pidx P_AI_XI   = 5'd14;
    localparam t_pidx P_AR_XI   = 5'd15;
    localparam t_pidx P_AI_XR   = 5'd16;
    localparam t_pidx P_AR_YR   = 5'd17;
    localparam t_pidx P_AI_YI   = 5'd18;
    localparam t_pidx P_AR_YI   = 5'd19;
    localparam t_pidx P_AI_YR   = 5'd20;
    localparam t_pidx P_XR_XI   = 5'd21;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP1,
        ST_PREP2,
        ST_DIV_CHK,
        ST_DIV_RUN,
        ST_LOOP,
        ST_CHECK,
        ST_UPD1,
        ST_UPD2,
        ST_UPD3
    } t_state;

    typedef struct packed {
        logic signed [31:0] start_real;
        logic signed [31:0] start_imag;
    } t_in_item;

    typedef struct packed {
        logic [STEP_W-1:0] step_count;
        logic              escaped;
    } t_out_item;

    function automatic t_q q_sat_raw(input t_raw v);
        t_q r;
        if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
            r = Q_MAX;
        end else if (v < -64'sh0000_8000_0000_0000) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic t_q q_sat49(input logic signed [Q_W:0] s);
        t_q r;
        if (s[Q_W] != s[Q_W-1]) begin
            r = s[Q_W] ? Q_MIN : Q_MAX;
        end else begin
            r = s[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic t_q q_add(input t_q a, input t_q b);
        logic signed [Q_W:0] s;
        s = 49'(a) + 49'(b);
        return q_sat49(s);
    endfunction

    function automatic t_q q_sub(input t_q a, input t_q b);
        logic signed [Q_W:0] s;
        s = 49'(a) - 49'(b);
        return q_sat49(s);
    endfunction

    // register format to Q16.32, shift amount fixed at elaboration
    function automatic t_q from_reg(input logic [31:0] raw, input int frac);
        logic signed [79:0] v;
        t_q r;
        v = {{48{raw[31]}}, raw};
        if (frac <= 32) begin
            v = v <<< (32 - frac);
        end else begin
            v = v >>> (frac - 32);
        end
        if (v > 80'sh0000_0000_7FFF_FFFF_FFFF) begin
            r = Q_MAX;
        end else if (v < -80'sh0000_0000_8000_0000_0000) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/semi_parabolic_escape_iteration_unit.sv]
// semi-parabolic escape iteration unit, top level
// one shared 25x25 multiplier and a restoring divider under a sequencer; uses spei_pkg
`default_nettype none

// sequence: setup products, then the two divisions of s (a saturating one is skipped),
//   then 13 products per step on the shared multiplier
// throughput: one item at a time; the input stalls until its result is registered
// reset: synchronous active low, clears control state and loads register defaults

module semi_parabolic_escape_iteration_unit #(
    parameter int ITER_WIDTH = spei_pkg::ITER_WIDTH_DEF,
    parameter int FRAC_BITS  = spei_pkg::FRAC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  spei_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output spei_pkg::t_out_item                o_out_data,
    input  wire                                i_cfg_we,
    input  wire [spei_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [spei_pkg::CFG_W-1:0]          i_cfg_data
);

    // configuration
    logic [31:0]                 r_eps_real, r_eps_imag, r_coef_real, r_coef_imag;
    logic [ITER_WIDTH-1:0]       r_max_iter;
    logic [spei_pkg::ESC_W-1:0]  r_escape_limit;

    spei_pkg::t_state r_state, n_state;

    // datapath values
    spei_pkg::t_q r_er, r_ei, r_ar, r_ai, r_dr, r_di, r_e2r, r_e2i;
    spei_pkg::t_q r_den, r_nr, r_ni, r_sr, r_si;
    spei_pkg::t_q r_xr, r_xi, r_yr, r_yi, r_tr, r_ti;
    spei_pkg::t_q r_axr, r_axi, r_ayr, r_ayi, r_x2r, r_x2i, r_t1r, r_t1i;
    spei_pkg::t_raw r_prod [0:spei_pkg::NUM_PROD-1];
    logic [ITER_WIDTH-1:0] r_iter;

    // shared multiplier
    spei_pkg::t_pidx              r_pidx;
    logic [2:0]                   r_part;
    logic signed [49:0]           r_pp;
    logic [1:0]                   r_pp_sh;
    logic signed [spei_pkg::ACC_W-1:0] r_acc;
    spei_pkg::t_q                 w_op_a, w_op_b;
    logic signed [24:0]           w_half_a, w_half_b;
    logic signed [spei_pkg::ACC_W-1:0] w_pp_ext, w_acc_sum;

    // divider
    logic                         r_div_sel, r_dneg;
    logic [47:0]                  r_rem;
    logic [spei_pkg::QUO_W-1:0]   r_dsh, r_quo;
    logic [5:0]                   r_dcnt;
    spei_pkg::t_q                 w_num;
    logic                         w_num_neg;
    logic [47:0]                  w_mag;
    logic                         w_div_ovf;
    logic [48:0]                  w_rs;
    logic                         w_ge;
    logic [spei_pkg::QUO_W-1:0]   w_quo;
    spei_pkg::t_q                 w_quo_s, w_sat_s;

    // escape check
    logic [64:0] w_nx, w_ny;
    logic [65:0] w_nsum;
    logic        w_escape;

    // control
    logic w_accept, w_out_free, w_mul_last, w_at_limit;

    spei_pkg::t_out_item r_out;
    logic                r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps_real     <= spei_pkg::RST_EPS_REAL;
            r_eps_imag     <= spei_pkg::RST_EPS_IMAG;
            r_coef_real    <= spei_pkg::RST_COEF_REAL;
            r_coef_imag    <= spei_pkg::RST_COEF_IMAG;
            r_max_iter     <= ITER_WIDTH'(spei_pkg::RST_MAX_ITER);
            r_escape_limit <= spei_pkg::RST_ESCAPE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spei_pkg::CFG_EPS_REAL:     r_eps_real     <= i_cfg_data[31:0];
                spei_pkg::CFG_EPS_IMAG:     r_eps_imag     <= i_cfg_data[31:0];
                spei_pkg::CFG_COEF_REAL:    r_coef_real    <= i_cfg_data[31:0];
                spei_pkg::CFG_COEF_IMAG:    r_coef_imag    <= i_cfg_data[31:0];
                spei_pkg::CFG_MAX_ITER:     r_max_iter     <= i_cfg_data[ITER_WIDTH-1:0];
                spei_pkg::CFG_ESCAPE_LIMIT: r_escape_limit <= i_cfg_data[spei_pkg::ESC_W-1:0];
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_pidx)
            spei_pkg::P_ER_ER:  begin w_op_a = r_er;  w_op_b = r_er; end
            spei_pkg::P_EI_EI:  begin w_op_a = r_ei;  w_op_b = r_ei; end
            spei_pkg::P_ER_EI:  begin w_op_a = r_er;  w_op_b = r_ei; end
            spei_pkg::P_DR_DR:  begin w_op_a = r_dr;  w_op_b = r_dr; end
            spei_pkg::P_DI_DI:  begin w_op_a = r_di;  w_op_b = r_di; end
            spei_pkg::P_E2R_DR: begin w_op_a = r_e2r; w_op_b = r_dr; end
            spei_pkg::P_E2I_DI: begin w_op_a = r_e2i; w_op_b = r_di; end
            spei_pkg::P_E2I_DR: begin w_op_a = r_e2i; w_op_b = r_dr; end
            spei_pkg::P_E2R_DI: begin w_op_a = r_e2r; w_op_b = r_di; end
            spei_pkg::P_XR_XR:  begin w_op_a = r_xr;  w_op_b = r_xr; end
            spei_pkg::P_XI_XI:  begin w_op_a = r_xi;  w_op_b = r_xi; end
            spei_pkg::P_YR_YR:  begin w_op_a = r_yr;  w_op_b = r_yr; end
            spei_pkg::P_YI_YI:  begin w_op_a = r_yi;  w_op_b = r_yi; end
            spei_pkg::P_AR_XR:  begin w_op_a = r_ar;  w_op_b = r_xr; end
            spei_pkg::P_AI_XI:  begin w_op_a = r_ai;  w_op_b = r_xi; end
            spei_pkg::P_AR_XI:  begin w_op_a = r_ar;  w_op_b = r_xi; end
            spei_pkg::P_AI_XR:  begin w_op_a = r_ai;  w_op_b = r_xr; end
            spei_pkg::P_AR_YR:  begin w_op_a = r_ar;  w_op_b = r_yr; end
            spei_pkg::P_AI_YI:  begin w_op_a = r_ai;  w_op_b = r_yi; end
            spei_pkg::P_AR_YI:  begin w_op_a = r_ar;  w_op_b = r_yi; end
            spei_pkg::P_AI_YR:  begin w_op_a = r_ai;  w_op_b = r_yr; end
            spei_pkg::P_XR_XI:  begin w_op_a = r_xr;  w_op_b = r_xi; end
            default:            begin w_op_a = '0;    w_op_b = '0;   end
        endcase
    end

    // parts: lo*lo, lo*hi, hi*lo, hi*hi; lower halves are unsigned
    always_comb begin
        w_half_a = r_part[1] ? $signed({w_op_a[47], w_op_a[47:24]})
                             : $signed({1'b0, w_op_a[23:0]});
        w_half_b = r_part[0] ? $signed({w_op_b[47], w_op_b[47:24]})
                             : $signed({1'b0, w_op_b[23:0]});
        case (r_pp_sh)
            2'd1:    w_pp_ext = spei_pkg::ACC_W'(r_pp) <<< spei_pkg::HALF_W;
            2'd2:    w_pp_ext = spei_pkg::ACC_W'(r_pp) <<< (2 * spei_pkg::HALF_W);
            default: w_pp_ext = spei_pkg::ACC_W'(r_pp);
        endcase
        w_acc_sum = r_acc + w_pp_ext;
    end

    // divider datapath
    always_comb begin
        w_num     = r_div_sel ? r_ni : r_nr;
        w_num_neg = w_num[47];
        w_mag     = w_num_neg ? 48'(-49'(w_num)) : 48'(w_num);
        w_div_ovf = {16'b0, w_mag} >= {2'b0, r_den[46:0], 15'b0};
        w_sat_s   = w_num_neg ? spei_pkg::Q_MIN : spei_pkg::Q_MAX;
        w_rs      = {r_rem, r_dsh[spei_pkg::QUO_W-1]};
        w_ge      = w_rs >= {2'b0, r_den[46:0]};
        w_quo     = {r_quo[spei_pkg::QUO_W-2:0], w_ge};
        w_quo_s   = r_dneg ? -spei_pkg::t_q'({1'b0, w_quo}) : spei_pkg::t_q'({1'b0, w_quo});
    end

    // norms from the raw squares, saturation counts as escape
    always_comb begin
        w_nx     = {1'b0, r_prod[spei_pkg::P_XR_XR]} + {1'b0, r_prod[spei_pkg::P_XI_XI]};
        w_ny     = {1'b0, r_prod[spei_pkg::P_YR_YR]} + {1'b0, r_prod[spei_pkg::P_YI_YI]};
        w_nsum   = {1'b0, w_nx} + {1'b0, w_ny};
        w_escape = (w_nx > 65'h7FFF_FFFF_FFFF) || (w_ny > 65'h7FFF_FFFF_FFFF)
                || (w_nsum >= {18'b0, r_escape_limit, 32'b0});
    end

    // control outputs
    always_comb begin
        o_in_stall = (r_state != spei_pkg::ST_IDLE);
        w_accept   = i_in_valid && (r_state == spei_pkg::ST_IDLE);
        w_out_free = !r_out_valid || !i_out_stall;
        w_mul_last = (r_part == 3'd4);
        w_at_limit = (r_iter == r_max_iter);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spei_pkg::ST_IDLE: begin
                if (w_accept) n_state = spei_pkg::ST_MUL;
            end
            spei_pkg::ST_MUL: begin
                if (w_mul_last) begin
                    case (r_pidx)
                        spei_pkg::P_ER_EI:  n_state = spei_pkg::ST_PREP1;
                        spei_pkg::P_E2R_DI: n_state = spei_pkg::ST_PREP2;
                        spei_pkg::P_YI_YI:  n_state = spei_pkg::ST_CHECK;
                        spei_pkg::P_XR_XI:  n_state = spei_pkg::ST_UPD1;
                        default:            n_state = spei_pkg::ST_MUL;
                    endcase
                end
            end
            spei_pkg::ST_PREP1:   n_state = spei_pkg::ST_MUL;
            spei_pkg::ST_PREP2:   n_state = spei_pkg::ST_DIV_CHK;
            spei_pkg::ST_DIV_CHK: begin
                if (r_den != spei_pkg::Q_ZERO && !w_div_ovf) begin
                    n_state = spei_pkg::ST_DIV_RUN;
                end else if (r_div_sel) begin
                    n_state = spei_pkg::ST_LOOP;
                end
            end
            spei_pkg::ST_DIV_RUN: begin
                if (r_dcnt == 6'd1) begin
                    n_state = r_div_sel ? spei_pkg::ST_LOOP : spei_pkg::ST_DIV_CHK;
                end
            end
            spei_pkg::ST_LOOP: begin
                if (w_at_limit) begin
                    if (w_out_free) n_state = spei_pkg::ST_IDLE;
                end else begin
                    n_state = spei_pkg::ST_MUL;
                end
            end
            spei_pkg::ST_CHECK: begin
                if (w_escape) begin
                    if (w_out_free) n_state = spei_pkg::ST_IDLE;
                end else begin
                    n_state = spei_pkg::ST_MUL;
                end
            end
            spei_pkg::ST_UPD1: n_state = spei_pkg::ST_UPD2;
            spei_pkg::ST_UPD2: n_state = spei_pkg::ST_UPD3;
            spei_pkg::ST_UPD3: n_state = spei_pkg::ST_LOOP;
            default:           n_state = spei_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spei_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_part      <= '0;
            r_pidx      <= spei_pkg::P_ER_ER;
            r_div_sel   <= 1'b0;
            r_dcnt      <= '0;
            r_iter      <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == spei_pkg::ST_LOOP && w_at_limit && w_out_free)
                    || (r_state == spei_pkg::ST_CHECK && w_escape && w_out_free)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                spei_pkg::ST_IDLE: begin
                    r_part    <= '0;
                    r_pidx    <= spei_pkg::P_ER_ER;
                    r_div_sel <= 1'b0;
                    r_iter    <= '0;
                end
                spei_pkg::ST_MUL: begin
                    if (w_mul_last) begin
                        r_part <= '0;
                        r_pidx <= r_pidx + 5'd1;
                    end else begin
                        r_part <= r_part + 3'd1;
                    end
                end
                spei_pkg::ST_DIV_CHK: begin
                    if (r_den != spei_pkg::Q_ZERO && !w_div_ovf) begin
                        r_dcnt <= 6'(spei_pkg::QUO_W);
                    end else begin
                        r_div_sel <= 1'b1;
                    end
                end
                spei_pkg::ST_DIV_RUN: begin
                    r_dcnt <= r_dcnt - 6'd1;
                    if (r_dcnt == 6'd1) r_div_sel <= 1'b1;
                end
                spei_pkg::ST_LOOP:  r_pidx <= spei_pkg::P_XR_XR;
                spei_pkg::ST_UPD3:  r_iter <= r_iter + 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            spei_pkg::ST_IDLE: begin
                r_er <= spei_pkg::from_reg(r_eps_real, FRAC_BITS);
                r_ei <= spei_pkg::from_reg(r_eps_imag, FRAC_BITS);
                r_ar <= spei_pkg::from_reg(r_coef_real, FRAC_BITS);
                r_ai <= spei_pkg::from_reg(r_coef_imag, FRAC_BITS);
                r_xr <= spei_pkg::from_reg(i_in_data.start_real, FRAC_BITS);
                r_xi <= spei_pkg::from_reg(i_in_data.start_imag, FRAC_BITS);
                r_yr <= spei_pkg::from_reg(i_in_data.start_real, FRAC_BITS);
                r_yi <= spei_pkg::from_reg(i_in_data.start_imag, FRAC_BITS);
            end
            spei_pkg::ST_MUL: begin
                if (r_part != 3'd4) begin
                    r_pp <= w_half_a * w_half_b;
                    case (r_part)
                        3'd0:    r_pp_sh <= 2'd0;
                        3'd3:    r_pp_sh <= 2'd2;
                        default: r_pp_sh <= 2'd1;
                    endcase
                end
                if (r_part == 3'd0) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= w_acc_sum;
                end
                if (w_mul_last) begin
                    // floor shift by 32 of the exact product
                    r_prod[r_pidx] <= w_acc_sum[spei_pkg::ACC_W-1:32];
                end
            end
            spei_pkg::ST_PREP1: begin
                r_e2r <= spei_pkg::q_sub(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_ER_ER]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_EI_EI]));
                r_e2i <= spei_pkg::q_add(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_ER_EI]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_ER_EI]));
                r_dr  <= spei_pkg::q_sub(spei_pkg::Q_ONE, r_ar);
                r_di  <= spei_pkg::q_sub(spei_pkg::Q_ZERO, r_ai);
            end
            spei_pkg::ST_PREP2: begin
                r_den <= spei_pkg::q_add(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_DR_DR]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_DI_DI]));
                r_nr  <= spei_pkg::q_add(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_E2R_DR]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_E2I_DI]));
                r_ni  <= spei_pkg::q_sub(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_E2I_DR]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_E2R_DI]));
            end
            spei_pkg::ST_DIV_CHK: begin
                r_dneg <= w_num_neg;
                r_rem  <= 48'(w_mag >> 15);
                r_dsh  <= {w_mag[14:0], 32'b0};
                r_quo  <= '0;
                // zero divisor or integer part of 16 bits or more saturates
                if (r_den == spei_pkg::Q_ZERO || w_div_ovf) begin
                    if (r_div_sel) r_si <= w_sat_s;
                    else           r_sr <= w_sat_s;
                end
            end
            spei_pkg::ST_DIV_RUN: begin
                r_rem <= w_ge ? 48'(w_rs - {2'b0, r_den[46:0]}) : w_rs[47:0];
                r_dsh <= {r_dsh[spei_pkg::QUO_W-2:0], 1'b0};
                r_quo <= w_quo;
                if (r_dcnt == 6'd1) begin
                    if (r_div_sel) r_si <= w_quo_s;
                    else           r_sr <= w_quo_s;
                end
            end
            spei_pkg::ST_LOOP: begin
                if (w_at_limit && w_out_free) begin
                    r_out.step_count <= '0;
                    r_out.escaped    <= 1'b0;
                end
            end
            spei_pkg::ST_CHECK: begin
                if (w_escape && w_out_free) begin
                    r_out.step_count <= spei_pkg::STEP_W'(r_iter);
                    r_out.escaped    <= 1'b1;
                end
            end
            spei_pkg::ST_UPD1: begin
                r_tr  <= spei_pkg::q_add(r_xr, r_sr);
                r_ti  <= spei_pkg::q_add(r_xi, r_si);
                r_axr <= spei_pkg::q_sub(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_AR_XR]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_AI_XI]));
                r_axi <= spei_pkg::q_add(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_AR_XI]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_AI_XR]));
                r_ayr <= spei_pkg::q_sub(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_AR_YR]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_AI_YI]));
                r_ayi <= spei_pkg::q_add(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_AR_YI]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_AI_YR]));
                r_x2r <= spei_pkg::q_sub(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_XR_XR]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_XI_XI]));
                r_x2i <= spei_pkg::q_add(spei_pkg::q_sat_raw(r_prod[spei_pkg::P_XR_XI]),
                                         spei_pkg::q_sat_raw(r_prod[spei_pkg::P_XR_XI]));
            end
            spei_pkg::ST_UPD2: begin
                r_t1r <= spei_pkg::q_sub(spei_pkg::q_add(r_xr, r_axr), r_ayr);
                r_t1i <= spei_pkg::q_sub(spei_pkg::q_add(r_xi, r_axi), r_ayi);
            end
            spei_pkg::ST_UPD3: begin
                r_xr <= spei_pkg::q_add(spei_pkg::q_add(r_t1r, r_x2r), r_sr);
                r_xi <= spei_pkg::q_add(spei_pkg::q_add(r_t1i, r_x2i), r_si);
                r_yr <= r_tr;
                r_yi <= r_ti;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/spei_checker.sv]
// port checker for the semi-parabolic escape iteration unit, bound to the top level
// uses spei_pkg for the beat types
`default_nettype none

module spei_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input spei_pkg::t_out_item o_out_data
);

    // a held output beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // one item at a time: after an input beat the input stalls
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // bounded points report a zero count
    a_bounded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.escaped |-> o_out_data.step_count == '0)
        else $error("bounded result with nonzero count");

    // reset drops the output beat
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind semi_parabolic_escape_iteration_unit spei_checker u_spei_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

[tb/sv/tb_semi_parabolic_escape_iteration_unit.sv]
// testbench for semi_parabolic_escape_iteration_unit: directed table, then random phases
// checks every result beat against a typed expectation or a local fixed point predictor; uses spei_pkg
`default_nettype none

module tb_semi_parabolic_escape_iteration_unit;

    localparam int     FRAC      = spei_pkg::FRAC_BITS_DEF;
    localparam longint QHI       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint QLO       = -QHI - 1;
    localparam longint QONE      = 64'sh0000_0001_0000_0000;
    localparam int     WD_LIMIT  = 60000;
    localparam int     HOLD_LEN  = 800;
    localparam int     N_PHASES  = 12;
    localparam int     PHASE_LEN = 150;

    typedef struct {
        logic [31:0] eps_r;
        logic [31:0] eps_i;
        logic [31:0] coef_r;
        logic [31:0] coef_i;
        logic [15:0] iter_lim;
        logic [15:0] esc_lim;
    } t_cfg;

    typedef struct {
        int                  cfg_sel;
        logic [31:0]         re;
        logic [31:0]         im;
        bit                  typed;
        spei_pkg::t_out_item res;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    spei_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    spei_pkg::t_out_item o_out_data;
    logic                i_cfg_we;
    logic [spei_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [spei_pkg::CFG_W-1:0]     i_cfg_data;

    semi_parabolic_escape_iteration_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_cfg                cur_cfg;
    spei_pkg::t_out_item pending_counts[$];
    int                  errors;
    int                  send_pct;
    int                  recv_pct;
    bit                  hold_req;
    int                  quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- fixed point predictor ----------------
    function automatic longint sat48(input longint v);
        if (v > QHI) return QHI;
        if (v < QLO) return QLO;
        return v;
    endfunction

    function automatic longint to_q(input logic [31:0] raw);
        longint v;
        v = longint'($signed(raw));
        return sat48(v * (64'sd1 <<< (32 - FRAC)));
    endfunction

    // exact product, floor shift by 32, not saturated
    function automatic longint mul_floor(input longint a, input longint b);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] p;
        pa = a;
        pb = b;
        p  = pa * pb;
        p  = p >>> 32;
        return longint'(p[63:0]);
    endfunction

    function automatic longint qm(input longint a, input longint b);
        return sat48(mul_floor(a, b));
    endfunction

    function automatic longint q_div(input longint num, input longint den);
        logic [127:0] mag;
        logic [127:0] q;
        if (den <= 0) return (num < 0) ? QLO : QHI;
        mag = (num < 0) ? -num : num;
        if ((mag / den) >= (128'd1 << 15)) return (num < 0) ? QLO : QHI;
        q = (mag << 32) / den;
        return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic spei_pkg::t_out_item predict_escape(input logic [31:0] re,
                                                            input logic [31:0] im);
        spei_pkg::t_out_item r;
        longint er, ei, ar, ai, e2r, e2i, dr, di, den, nr, ni, sr, si;
        longint xr, xi, yr, yi, tr, ti, nx, ny, lim;
        longint axr, axi, ayr, ayi, x2r, x2i;
        bit     over;
        int     k;
        er  = to_q(cur_cfg.eps_r);
        ei  = to_q(cur_cfg.eps_i);
        ar  = to_q(cur_cfg.coef_r);
        ai  = to_q(cur_cfg.coef_i);
        e2r = sat48(qm(er, er) - qm(ei, ei));
        e2i = sat48(qm(er, ei) + qm(er, ei));
        dr  = sat48(QONE - ar);
        di  = sat48(-ai);
        den = sat48(qm(dr, dr) + qm(di, di));
        nr  = sat48(qm(e2r, dr) + qm(e2i, di));
        ni  = sat48(qm(e2i, dr) - qm(e2r, di));
        sr  = q_div(nr, den);
        si  = q_div(ni, den);
        xr  = to_q(re);
        xi  = to_q(im);
        yr  = xr;
        yi  = xi;
        lim = longint'(cur_cfg.esc_lim) <<< 32;
        r   = '0;
        for (k = 0; k < int'(cur_cfg.iter_lim); k++) begin
            over = 1'b0;
            nx = mul_floor(xr, xr) + mul_floor(xi, xi);
            if (nx > QHI) begin
                over = 1'b1;
                nx = QHI;
            end
            ny = mul_floor(yr, yr) + mul_floor(yi, yi);
            if (ny > QHI) begin
                over = 1'b1;
                ny = QHI;
            end
            if (over || (nx + ny >= lim)) begin
                r.step_count = k[15:0];
                r.escaped    = 1'b1;
                return r;
            end
            tr  = sat48(xr + sr);
            ti  = sat48(xi + si);
            axr = sat48(qm(ar, xr) - qm(ai, xi));
            axi = sat48(qm(ar, xi) + qm(ai, xr));
            ayr = sat48(qm(ar, yr) - qm(ai, yi));
            ayi = sat48(qm(ar, yi) + qm(ai, yr));
            x2r = sat48(qm(xr, xr) - qm(xi, xi));
            x2i = sat48(qm(xr, xi) + qm(xr, xi));
            xr  = sat48(sat48(sat48(sat48(xr + axr) - ayr) + x2r) + sr);
            xi  = sat48(sat48(sat48(sat48(xi + axi) - ayi) + x2i) + si);
            yr  = tr;
            yi  = ti;
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    task automatic write_reg(input logic [spei_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic load_cfg(input t_cfg c);
        write_reg(spei_pkg::CFG_EPS_REAL, c.eps_r);
        write_reg(spei_pkg::CFG_EPS_IMAG, c.eps_i);
        write_reg(spei_pkg::CFG_COEF_REAL, c.coef_r);
        write_reg(spei_pkg::CFG_COEF_IMAG, c.coef_i);
        write_reg(spei_pkg::CFG_MAX_ITER, {16'd0, c.iter_lim});
        write_reg(spei_pkg::CFG_ESCAPE_LIMIT, {16'd0, c.esc_lim});
        cur_cfg = c;
    endtask

    // wait until every result is back, then let the block settle
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_counts.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // ---------------- input side ----------------
    task automatic send_point(input logic [31:0] re, input logic [31:0] im,
                              input bit typed, input spei_pkg::t_out_item res);
        while ($urandom_range(0, 99) < send_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid           = 1'b1;
        i_in_data.start_real = re;
        i_in_data.start_imag = im;
        do @(posedge i_clk); while (o_in_stall);
        pending_counts.push_back(typed ? res : predict_escape(re, im));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_point();
        logic [31:0] v;
        v = $urandom;
        return $signed(v) >>> $urandom_range(0, 8);
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'h1000_0000;
            1: return 32'h1000_0001;
            2: return 32'h0FFF_FFFF;
            3: return $signed($urandom) >>> $urandom_range(2, 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.eps_r    = ($urandom_range(0, 3) == 0) ? 32'd0 : rand_point();
        c.eps_i    = ($urandom_range(0, 3) == 0) ? 32'd0 : rand_point();
        c.coef_r   = rand_coef();
        c.coef_i   = ($urandom_range(0, 2) == 0) ? 32'd0 : rand_coef();
        c.iter_lim = 16'($urandom_range(0, 5));
        c.esc_lim  = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 20))
                                                 : 16'($urandom_range(0, 65535));
        return c;
    endfunction

    // ---------------- output side ----------------
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < recv_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        spei_pkg::t_out_item want;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_counts.size() == 0) begin
                if (errors < 10) $display("unexpected result beat %p", o_out_data);
                errors++;
            end else begin
                want = pending_counts.pop_front();
                if (o_out_data.step_count !== want.step_count
                        || o_out_data.escaped !== want.escaped) begin
                    if (errors < 10) begin
                        $display("mismatch: step_count exp %0d got %0d, escaped exp %0b got %0b",
                                 want.step_count, o_out_data.step_count,
                                 want.escaped, o_out_data.escaped);
                    end
                    errors++;
                end
            end
        end
    end

    // ---------------- main sequence ----------------
    t_cfg cfg_sets[8];
    t_row rows[$];

    function automatic t_row mk(input int sel, input logic [31:0] re, input logic [31:0] im,
                                input bit typed, input logic [15:0] sc, input logic esc);
        t_row r;
        r.cfg_sel        = sel;
        r.re             = re;
        r.im             = im;
        r.typed          = typed;
        r.res.step_count = sc;
        r.res.escaped    = esc;
        return r;
    endfunction

    initial begin
        int cur_sel;
        t_cfg c;
        errors       = 0;
        quiet_cycles = 0;
        hold_req     = 1'b0;
        send_pct     = 0;
        recv_pct     = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        cur_cfg = '{spei_pkg::RST_EPS_REAL, spei_pkg::RST_EPS_IMAG, spei_pkg::RST_COEF_REAL,
                    spei_pkg::RST_COEF_IMAG, 16'(spei_pkg::RST_MAX_ITER),
                    spei_pkg::RST_ESCAPE_LIMIT};

        cfg_sets[0] = cur_cfg;
        cfg_sets[1] = '{cur_cfg.eps_r, 32'd0, cur_cfg.coef_r, 32'd0, 16'd0, 16'd10000};
        // zero escape limit with the largest step limit: escape at once
        cfg_sets[2] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        16'hFFFF, 16'd0};
        // a = 1 exactly, divisor zero
        cfg_sets[3] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1000_0000, 32'd0, 16'd5, 16'd10000};
        cfg_sets[4] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        16'd6, 16'hFFFF};
        cfg_sets[5] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        16'd3, 16'd1};
        cfg_sets[6] = '{32'h0100_0000, 32'hFF00_0000, 32'h0400_0000, 32'h0200_0000,
                        16'd20, 16'd4};
        // a just above 1: divisor too small to register, negative numerator
        cfg_sets[7] = '{32'h0CCC_CCCD, 32'd0, 32'h1000_0001, 32'd0, 16'd5, 16'd100};

        rows.push_back(mk(0, 32'd0, 32'd0, 0, 0, 0));
        rows.push_back(mk(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
        rows.push_back(mk(0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
        rows.push_back(mk(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
        rows.push_back(mk(0, 32'h1000_0000, 32'd0, 0, 0, 0));
        rows.push_back(mk(1, 32'd0, 32'd0, 1, 0, 0));
        rows.push_back(mk(1, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0));
        rows.push_back(mk(2, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 1));
        rows.push_back(mk(2, 32'd0, 32'd0, 1, 0, 1));
        rows.push_back(mk(3, 32'd0, 32'd0, 0, 0, 0));
        rows.push_back(mk(3, 32'h0010_0000, 32'd0, 0, 0, 0));
        rows.push_back(mk(3, 32'h8000_0000, 32'd0, 0, 0, 0));
        rows.push_back(mk(4, 32'd0, 32'd0, 0, 0, 0));
        rows.push_back(mk(4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
        rows.push_back(mk(5, 32'd0, 32'd0, 0, 0, 0));
        rows.push_back(mk(5, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
        rows.push_back(mk(6, 32'h0800_0000, 32'h0800_0000, 0, 0, 0));
        rows.push_back(mk(6, 32'd0, 32'd0, 0, 0, 0));
        rows.push_back(mk(6, 32'hF000_0000, 32'd0, 0, 0, 0));
        rows.push_back(mk(7, 32'd0, 32'd0, 0, 0, 0));
        rows.push_back(mk(7, 32'h0400_0000, 32'hFC00_0000, 0, 0, 0));

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        cur_sel = 0;
        foreach (rows[n]) begin
            if (rows[n].cfg_sel != cur_sel) begin
                drain();
                cur_sel = rows[n].cfg_sel;
                load_cfg(cfg_sets[cur_sel]);
            end
            send_point(rows[n].re, rows[n].im, rows[n].typed, rows[n].res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            if (ph < 4) begin
                send_pct = 35;
                recv_pct = 63;
            end else if (ph < 8) begin
                send_pct = 63;
                recv_pct = 35;
            end else begin
                send_pct = 0;
                recv_pct = 0;
            end
            c = rand_cfg();
            load_cfg(c);
            // long receiver hold-off while items keep coming
            if (ph == 1) hold_req = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++) begin
                send_point(rand_point(), rand_point(), 0, '0);
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending_counts.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
